### sv/moldudp64_packet_parser_top_defines.svh
// ----------------------------------------------------------------------------
// moldudp64_packet_parser_top_defines.svh
// Assertion macros shared by the parser's modules.
// ----------------------------------------------------------------------------
`ifndef MOLDUDP64_PACKET_PARSER_TOP_DEFINES_SVH
`define MOLDUDP64_PACKET_PARSER_TOP_DEFINES_SVH

// Invariant that must hold at every clock edge out of reset
`define MPP_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Same-cycle implication
`define MPP_CHECK_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

### sv/mpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpp_pkg
// Types and constants of the MoldUDP64 packet parser.
// ----------------------------------------------------------------------------
package mpp_pkg;

    localparam int SESSION_BYTES   = 10;
    localparam int COUNT_START     = 18;
    localparam int HEADER_BYTES    = 20;
    localparam logic [15:0] SESSION_END_MARK = 16'hFFFF;
    localparam int MPP_QUEUE_DEPTH = 4;

    // Parser phase, one-hot
    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_LEN_HI = 5'b00010,
        PH_LEN_LO = 5'b00100,
        PH_BODY   = 5'b01000,
        PH_DONE   = 5'b10000
    } mpp_phase_t;

    typedef enum logic [1:0] {
        KIND_SESSION = 2'd0,
        KIND_MESSAGE = 2'd1,
        KIND_VERDICT = 2'd2
    } mpp_kind_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SHORT_HEADER = 3'd1,
        ST_CUT_LENGTH   = 3'd2,
        ST_CUT_MESSAGE  = 3'd3,
        ST_TRAILING     = 3'd4
    } mpp_status_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } mpp_in_t;

    typedef struct packed {
        mpp_kind_t   kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [15:0] msg_index;
        logic [15:0] message_length;
        logic        msg_end;
        logic [63:0] sequence_number;
        logic [15:0] msg_count;
        logic        session_end;
        mpp_status_t status;
        logic        run_last;
    } mpp_out_t;

    // One classified input beat: an optional data result and an optional verdict
    typedef struct packed {
        logic        has_data;
        mpp_kind_t   kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [15:0] msg_index;
        logic [15:0] message_length;
        logic        msg_end;
        logic        has_verdict;
        logic [63:0] sequence_number;
        logic [15:0] msg_count;
        logic        session_end;
        mpp_status_t status;
    } mpp_entry_t;

endpackage

### sv/moldudp64_packet_parser_top.sv
`timescale 1ns / 1ps
// A byte's first result is registered in the entry queue and then in the output register.
// Throughput: one byte per cycle in unless the queue is full, one result per cycle out
// while m_ready is high; a packet's last byte yields up to two results, output one after the other.
// The entry queue between parser and result stage sets how long input keeps flowing under stall.
// Reset: synchronous, active-low aresetn clears parser state, queue and output valid.
// ----------------------------------------------------------------------------
// moldudp64_packet_parser_top
// MoldUDP64 downstream packet parser: session bytes, message bytes and verdict.
// ----------------------------------------------------------------------------
module moldudp64_packet_parser_top import mpp_pkg::*; #(
    parameter int QUEUE_DEPTH = MPP_QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  mpp_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output mpp_out_t m_data
);

    logic       queue_full;
    logic       push;
    mpp_entry_t push_entry;
    logic       pop;
    logic       head_valid;
    mpp_entry_t head_entry;

    // Byte parser
    mpp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Entry queue
    mpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // Result stage
    mpp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

### sv/mpp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpp_front
// Byte parser: tracks header, length prefixes and message bodies, and turns
// each accepted beat that yields a data result or a verdict into one queue entry.
// ----------------------------------------------------------------------------
module mpp_front import mpp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  mpp_in_t    s_data,
    input  logic       queue_full,
    output logic       push,
    output mpp_entry_t push_entry
);

    mpp_phase_t  phase_reg, phase_next;
    logic [4:0]  header_pos_reg, header_pos_next;
    logic [63:0] seq_accum_reg, seq_accum_next;
    logic [15:0] count_accum_reg, count_accum_next;
    logic [15:0] msgs_left_reg, msgs_left_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [15:0] body_left_reg, body_left_next;
    logic [15:0] body_pos_reg, body_pos_next;
    logic [15:0] msg_number_reg, msg_number_next;
    mpp_status_t error_code_reg, error_code_next;

    logic        accept;
    logic        msg_done;
    logic [15:0] new_length;
    logic [7:0]  b;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.byte_value;
    assign new_length = {length_high_reg, b};

    // Next state and entry contents for the current beat
    always_comb begin
        phase_next       = phase_reg;
        header_pos_next  = header_pos_reg;
        seq_accum_next   = seq_accum_reg;
        count_accum_next = count_accum_reg;
        msgs_left_next   = msgs_left_reg;
        length_high_next = length_high_reg;
        body_left_next   = body_left_reg;
        body_pos_next    = body_pos_reg;
        msg_number_next  = msg_number_reg;
        error_code_next  = error_code_reg;
        msg_done         = 1'b0;
        push_entry       = '0;

        unique case (phase_reg)
            PH_HEADER: begin
                if (header_pos_reg < 5'(SESSION_BYTES)) begin
                    push_entry.has_data   = 1'b1;
                    push_entry.kind       = KIND_SESSION;
                    push_entry.data_byte  = b;
                    push_entry.byte_index = 16'(header_pos_reg);
                end else if (header_pos_reg < 5'(COUNT_START)) begin
                    seq_accum_next = {seq_accum_reg[55:0], b};
                end else begin
                    count_accum_next = {count_accum_reg[7:0], b};
                end
                header_pos_next = header_pos_reg + 5'd1;
                if (header_pos_next >= 5'(HEADER_BYTES)) begin
                    if (count_accum_next == SESSION_END_MARK || count_accum_next == 16'd0) begin
                        phase_next = PH_DONE;
                    end else begin
                        msgs_left_next = count_accum_next;
                        phase_next     = PH_LEN_HI;
                    end
                end
            end
            PH_LEN_HI: begin
                length_high_next = b;
                phase_next       = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                body_left_next = new_length;
                body_pos_next  = 16'd0;
                if (new_length == 16'd0) begin
                    // empty message gives a single marker
                    push_entry.has_data  = 1'b1;
                    push_entry.kind      = KIND_MESSAGE;
                    push_entry.msg_index = msg_number_reg;
                    push_entry.msg_end   = 1'b1;
                    msg_done             = 1'b1;
                end else begin
                    phase_next = PH_BODY;
                end
            end
            PH_BODY: begin
                body_left_next            = body_left_reg - 16'd1;
                push_entry.has_data       = 1'b1;
                push_entry.kind           = KIND_MESSAGE;
                push_entry.data_byte      = b;
                push_entry.byte_index     = body_pos_reg;
                push_entry.msg_index      = msg_number_reg;
                push_entry.message_length = body_pos_reg + body_left_reg;
                push_entry.msg_end        = (body_left_next == 16'd0);
                body_pos_next             = body_pos_reg + 16'd1;
                msg_done                  = (body_left_next == 16'd0);
            end
            PH_DONE: begin
                // anything past the last message is trailing junk
                error_code_next = ST_TRAILING;
                phase_next      = PH_DONE;
            end
            default: begin
                phase_next = PH_HEADER;
            end
        endcase

        // message complete: advance ordinal, stop after the last one
        if (msg_done) begin
            msg_number_next = msg_number_reg + 16'd1;
            msgs_left_next  = msgs_left_reg - 16'd1;
            phase_next      = (msgs_left_reg == 16'd1) ? PH_DONE : PH_LEN_HI;
        end

        // verdict fields, taken from the updated state
        push_entry.has_verdict     = s_data.last_byte;
        push_entry.sequence_number = seq_accum_next;
        push_entry.msg_count       = count_accum_next;
        push_entry.session_end     = (header_pos_next >= 5'(HEADER_BYTES))
                                     && (count_accum_next == SESSION_END_MARK);
        unique case (phase_next)
            PH_HEADER: push_entry.status = ST_SHORT_HEADER;
            PH_LEN_HI: push_entry.status = ST_CUT_LENGTH;
            PH_LEN_LO: push_entry.status = ST_CUT_LENGTH;
            PH_BODY:   push_entry.status = ST_CUT_MESSAGE;
            default:   push_entry.status = error_code_next;
        endcase
    end

    assign push = accept && (push_entry.has_data || push_entry.has_verdict);

    // Parser state; a verdict returns everything to the reset values
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_data.last_byte)) begin
            phase_reg       <= PH_HEADER;
            header_pos_reg  <= '0;
            seq_accum_reg   <= '0;
            count_accum_reg <= '0;
            msgs_left_reg   <= '0;
            length_high_reg <= '0;
            body_left_reg   <= '0;
            body_pos_reg    <= '0;
            msg_number_reg  <= '0;
            error_code_reg  <= ST_OK;
        end else if (accept) begin
            phase_reg       <= phase_next;
            header_pos_reg  <= header_pos_next;
            seq_accum_reg   <= seq_accum_next;
            count_accum_reg <= count_accum_next;
            msgs_left_reg   <= msgs_left_next;
            length_high_reg <= length_high_next;
            body_left_reg   <= body_left_next;
            body_pos_reg    <= body_pos_next;
            msg_number_reg  <= msg_number_next;
            error_code_reg  <= error_code_next;
        end
    end

endmodule

### sv/mpp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpp_queue
// Small FIFO of parsed entries between the parser and the result stage.
// ----------------------------------------------------------------------------
`include "moldudp64_packet_parser_top_defines.svh"

module mpp_queue import mpp_pkg::*; #(
    parameter int DEPTH = MPP_QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  mpp_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output mpp_entry_t head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mpp_entry_t       slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slots[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    `MPP_CHECK(a_count_bound, count_reg <= CNT_W'(DEPTH), "queue count beyond depth")
    `MPP_CHECK_IMP(a_no_overflow, push, !full || pop, "push into full queue")
    `MPP_CHECK_IMP(a_empty_ptrs, count_reg == '0, rd_ptr_reg == wr_ptr_reg, "empty but ptrs differ")

endmodule

### sv/mpp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpp_back
// Result stage: expands each queue entry into one or two result beats and
// holds them in the output register.
// ----------------------------------------------------------------------------
`include "moldudp64_packet_parser_top_defines.svh"

module mpp_back import mpp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  mpp_entry_t head_entry,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output mpp_out_t   m_data
);

    logic     m_valid_reg, m_valid_next;
    mpp_out_t m_data_reg, m_data_next;
    logic     data_done_reg, data_done_next;
    logic     load;

    assign load    = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Pick the next beat: data result first, then the verdict
    always_comb begin
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        data_done_next = data_done_reg;
        pop            = 1'b0;
        if (load) begin
            m_valid_next = head_valid;
            if (head_valid) begin
                m_data_next = '0;
                if (head_entry.has_data && !data_done_reg) begin
                    m_data_next.kind           = head_entry.kind;
                    m_data_next.data_byte      = head_entry.data_byte;
                    m_data_next.byte_index     = head_entry.byte_index;
                    m_data_next.msg_index      = head_entry.msg_index;
                    m_data_next.message_length = head_entry.message_length;
                    m_data_next.msg_end        = head_entry.msg_end;
                    m_data_next.run_last       = !head_entry.has_verdict;
                    pop                        = !head_entry.has_verdict;
                    data_done_next             = head_entry.has_verdict;
                end else begin
                    m_data_next.kind            = KIND_VERDICT;
                    m_data_next.sequence_number = head_entry.sequence_number;
                    m_data_next.msg_count       = head_entry.msg_count;
                    m_data_next.session_end     = head_entry.session_end;
                    m_data_next.status          = head_entry.status;
                    m_data_next.run_last        = 1'b1;
                    pop                         = 1'b1;
                    data_done_next              = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            data_done_reg <= 1'b0;
        end else begin
            m_valid_reg   <= m_valid_next;
            data_done_reg <= data_done_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    `MPP_CHECK_IMP(a_pop_on_load, pop, load && head_valid, "entry popped without emitting")
    `MPP_CHECK_IMP(a_split_pending, data_done_reg, head_valid, "verdict half lost its entry")
    `MPP_CHECK_IMP(a_verdict_last, m_valid_reg && m_data_reg.kind == KIND_VERDICT, m_data_reg.run_last, "verdict not last of run")

endmodule
